>>> rtl/core/bisection_cubic_root_finder_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the bisection cubic root finder
// Shared property shorthands used by the evaluator and the core modules.
// ----------------------------------------------------------------------------
`ifndef BISECTION_CUBIC_ROOT_FINDER_CORE_MACROS_SVH
`define BISECTION_CUBIC_ROOT_FINDER_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BCRF_ASSERT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BCRF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/bcrf_pkg.sv
// ----------------------------------------------------------------------------
// Bisection cubic root finder package
// Widths, register map, status codes, reset values and shared types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bcrf_pkg;

    localparam int Q_W       = 24;
    localparam int COEF_W    = 32;
    localparam int TOL_W     = 16;
    localparam int ITER_W    = 7;
    localparam int STATUS_W  = 2;
    localparam int LIMB_W    = 32;
    localparam int PROD_W    = LIMB_W + 1 + Q_W;
    localparam int ACC_W     = 108;
    localparam int ADDR_W    = 5;
    localparam int DATA_W    = 32;
    localparam int REG_IDX_W = 3;

    localparam logic [1:0] LAST_STEP = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_CONVERGED = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NO_CHANGE = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_CAP       = 2'd2;

    localparam logic [REG_IDX_W-1:0] REG_COEF_CUBE   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_COEF_SQUARE = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_COEF_LINEAR = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_COEF_CONST  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_REL_TOL     = 3'd4;

    localparam logic [COEF_W-1:0] COEF_CUBE_RST   = 32'h0002_0000;
    localparam logic [COEF_W-1:0] COEF_SQUARE_RST = 32'h0000_0000;
    localparam logic [COEF_W-1:0] COEF_LINEAR_RST = 32'h0003_0000;
    localparam logic [COEF_W-1:0] COEF_CONST_RST  = 32'hFFFF_0000;
    localparam logic [TOL_W-1:0]  REL_TOL_RST     = 16'd66;

    typedef struct packed {
        logic [COEF_W-1:0] cube;
        logic [COEF_W-1:0] square;
        logic [COEF_W-1:0] linear;
        logic [COEF_W-1:0] bias;
        logic [TOL_W-1:0]  tol;
    } cfg_t;

    typedef struct packed {
        logic           start;
        logic [Q_W-1:0] x;
    } eval_req_t;

    typedef struct packed {
        logic done;
        logic neg;
        logic zero;
    } eval_rsp_t;

endpackage

>>> rtl/core/bcrf_regs.sv
// ----------------------------------------------------------------------------
// Configuration register file
// APB-style access to the four cubic coefficients and the tolerance.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bcrf_regs
    import bcrf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;
    cfg_t                 cfg_reg;
    cfg_t                 cfg_next;

    assign reg_idx = paddr[ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                REG_COEF_CUBE:   cfg_next.cube   = pwdata;
                REG_COEF_SQUARE: cfg_next.square = pwdata;
                REG_COEF_LINEAR: cfg_next.linear = pwdata;
                REG_COEF_CONST:  cfg_next.bias   = pwdata;
                REG_REL_TOL:     cfg_next.tol    = pwdata[TOL_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_COEF_CUBE:   prdata = cfg_reg.cube;
            REG_COEF_SQUARE: prdata = cfg_reg.square;
            REG_COEF_LINEAR: prdata = cfg_reg.linear;
            REG_COEF_CONST:  prdata = cfg_reg.bias;
            REG_REL_TOL:     prdata = {{(DATA_W-TOL_W){1'b0}}, cfg_reg.tol};
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cube   <= COEF_CUBE_RST;
            cfg_reg.square <= COEF_SQUARE_RST;
            cfg_reg.linear <= COEF_LINEAR_RST;
            cfg_reg.bias   <= COEF_CONST_RST;
            cfg_reg.tol    <= REL_TOL_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

>>> rtl/core/bcrf_cubic_eval.sv
// ----------------------------------------------------------------------------
// Cubic sign evaluator
// Exact Horner evaluation of the cubic on one shared 33x24 multiplier,
// one 32-bit limb per multiply, reporting only the sign of the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "bisection_cubic_root_finder_core_macros.svh"

module bcrf_cubic_eval
    import bcrf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  eval_req_t req,
    input  cfg_t      cfg,
    output eval_rsp_t rsp
);

    localparam logic [2:0] E_IDLE = 3'd0;
    localparam logic [2:0] E_MUL  = 3'd1;
    localparam logic [2:0] E_ADD  = 3'd2;
    localparam logic [2:0] E_COEF = 3'd3;
    localparam logic [2:0] E_DONE = 3'd4;

    logic [2:0]               state_reg;
    logic [2:0]               state_next;
    logic [1:0]               step_reg;
    logic [1:0]               step_next;
    logic [1:0]               limb_reg;
    logic [1:0]               limb_next;
    logic [ACC_W-1:0]         acc_reg;
    logic [ACC_W-1:0]         acc_next;
    logic [ACC_W-1:0]         res_reg;
    logic [ACC_W-1:0]         res_next;
    logic [ACC_W-1:0]         coef_term;
    logic [Q_W-1:0]           x_reg;
    logic [Q_W-1:0]           x_next;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;
    logic [LIMB_W-1:0]        limb_bits;
    logic signed [LIMB_W:0]   limb_op;

    always_comb
    begin
        case (limb_reg)
            2'd0:    limb_bits = acc_reg[LIMB_W-1:0];
            2'd1:    limb_bits = acc_reg[2*LIMB_W-1:LIMB_W];
            default: limb_bits = acc_reg[3*LIMB_W-1:2*LIMB_W];
        endcase
        limb_op   = {(limb_reg == step_reg) ? limb_bits[LIMB_W-1] : 1'b0, limb_bits};
        prod_next = limb_op * $signed(x_reg);
    end

    always_comb
    begin
        case (step_reg)
            2'd0:    coef_term = {{(ACC_W-COEF_W-16){cfg.square[COEF_W-1]}}, cfg.square, 16'b0};
            2'd1:    coef_term = {{(ACC_W-COEF_W-32){cfg.linear[COEF_W-1]}}, cfg.linear, 32'b0};
            default: coef_term = {{(ACC_W-COEF_W-48){cfg.bias[COEF_W-1]}}, cfg.bias, 48'b0};
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        limb_next  = limb_reg;
        acc_next   = acc_reg;
        res_next   = res_reg;
        x_next     = x_reg;
        unique case (state_reg)
            E_IDLE:
            begin
                if (req.start)
                begin
                    acc_next   = {{(ACC_W-COEF_W){cfg.cube[COEF_W-1]}}, cfg.cube};
                    res_next   = '0;
                    x_next     = req.x;
                    step_next  = 2'd0;
                    limb_next  = 2'd0;
                    state_next = E_MUL;
                end
            end
            E_MUL:
            begin
                state_next = E_ADD;
            end
            E_ADD:
            begin
                res_next = (res_reg << LIMB_W)
                         + {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
                if (limb_reg == 2'd0)
                begin
                    state_next = E_COEF;
                end
                else
                begin
                    limb_next  = limb_reg - 2'd1;
                    state_next = E_MUL;
                end
            end
            E_COEF:
            begin
                acc_next = res_reg + coef_term;
                res_next = '0;
                if (step_reg == LAST_STEP)
                begin
                    state_next = E_DONE;
                end
                else
                begin
                    step_next  = step_reg + 2'd1;
                    limb_next  = step_reg + 2'd1;
                    state_next = E_MUL;
                end
            end
            E_DONE:
            begin
                state_next = E_IDLE;
            end
            default:
            begin
                state_next = E_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= E_IDLE;
            step_reg  <= 2'd0;
            limb_reg  <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            limb_reg  <= limb_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        res_reg  <= res_next;
        x_reg    <= x_next;
        prod_reg <= prod_next;
    end

    assign rsp.done = (state_reg == E_DONE);
    assign rsp.neg  = acc_reg[ACC_W-1];
    assign rsp.zero = (acc_reg == '0);

    `BCRF_ASSERT(a_start_when_idle, clk, rst_n, req.start, state_reg == E_IDLE, "start while busy")
    `BCRF_ASSERT(a_limb_in_range, clk, rst_n, state_reg == E_MUL || state_reg == E_ADD, limb_reg <= step_reg, "limb beyond step")
    `BCRF_ASSERT_NEXT(a_done_single, clk, rst_n, rsp.done, !rsp.done, "done longer than one cycle")

endmodule

>>> rtl/core/bisection_cubic_root_finder_core.sv
// ----------------------------------------------------------------------------
// Bisection cubic root finder
// Finds a root of a programmable cubic inside a bracket by bisection.
//
// A request carries lower_bound and upper_bound (signed Q8.16) on a
// valid/ready channel. The user must write the cubic coefficients and the
// relative tolerance through the APB-style port only while the block is idle;
// the block does not enforce this. Reset loads 2, 0, 3, -1 and a tolerance
// of 66/65536, and leaves both channels empty. The block takes one request
// at a time. Both ends are evaluated first; when both values are non-zero
// with the same sign, the result goes out with no bisection step. Otherwise
// each bisection step is one pass of the cubic evaluator (six limb multiplies
// on one shared 33x24 multiplier, each followed by an accumulate, three
// coefficient adds and a done state) and a check state, up to MAX_ITER steps.
// The block is ready for the next request once the result is registered.
// The result sits in an output register, so a stalled receiver does not block
// the next request; the block only waits when a new result is ready while the
// previous one is still unclaimed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "bisection_cubic_root_finder_core_macros.svh"

module bisection_cubic_root_finder_core
    import bcrf_pkg::*;
#(
    parameter int MAX_ITER = 40
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output logic                pready,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [Q_W-1:0]      lower_bound,
    input  logic [Q_W-1:0]      upper_bound,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [Q_W-1:0]      root,
    output logic [ITER_W-1:0]   iterations,
    output logic [STATUS_W-1:0] status
);

    localparam logic [2:0] T_IDLE     = 3'd0;
    localparam logic [2:0] T_LO_GO    = 3'd1;
    localparam logic [2:0] T_LO_WAIT  = 3'd2;
    localparam logic [2:0] T_HI_GO    = 3'd3;
    localparam logic [2:0] T_HI_WAIT  = 3'd4;
    localparam logic [2:0] T_CHECK    = 3'd5;
    localparam logic [2:0] T_MID_WAIT = 3'd6;
    localparam logic [2:0] T_OUT      = 3'd7;

    cfg_t      cfg;
    eval_req_t eval_req;
    eval_rsp_t eval_rsp;

    logic [2:0]          state_reg;
    logic [2:0]          state_next;
    logic [Q_W-1:0]      lo_reg;
    logic [Q_W-1:0]      lo_next;
    logic [Q_W-1:0]      hi_reg;
    logic [Q_W-1:0]      hi_next;
    logic [Q_W-1:0]      mid_reg;
    logic [Q_W-1:0]      mid_next;
    logic [ITER_W-1:0]   iters_reg;
    logic [ITER_W-1:0]   iters_next;
    logic [STATUS_W-1:0] status_reg;
    logic [STATUS_W-1:0] status_next;
    logic                sl_neg_reg;
    logic                sl_neg_next;
    logic                sl_zero_reg;
    logic                sl_zero_next;

    logic                out_valid_reg;
    logic                out_valid_next;
    logic [Q_W-1:0]      root_reg;
    logic [ITER_W-1:0]   iter_out_reg;
    logic [STATUS_W-1:0] status_out_reg;
    logic                out_load;

    logic [Q_W:0]        mid_sum;
    logic [Q_W-1:0]      mid_calc;
    logic [Q_W:0]        diff;
    logic [Q_W:0]        abs_diff;
    logic [Q_W-1:0]      abs_hi;
    logic [Q_W+16:0]     lhs;
    logic [Q_W+15:0]     rhs;
    logic                not_conv;
    logic                cap_hit;
    logic                go_on;

    bcrf_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    bcrf_cubic_eval u_eval (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (eval_req),
        .cfg   (cfg),
        .rsp   (eval_rsp)
    );

    always_comb
    begin
        mid_sum  = {lo_reg[Q_W-1], lo_reg} + {hi_reg[Q_W-1], hi_reg};
        mid_calc = mid_sum[Q_W:1];
        diff     = {hi_reg[Q_W-1], hi_reg} - {lo_reg[Q_W-1], lo_reg};
        abs_diff = diff[Q_W] ? (~diff + 1'b1) : diff;
        abs_hi   = hi_reg[Q_W-1] ? (~hi_reg + 1'b1) : hi_reg;
        lhs      = {abs_diff, 16'b0};
        rhs      = cfg.tol * abs_hi;
        not_conv = lhs > {1'b0, rhs};
        cap_hit  = iters_reg >= ITER_W'(MAX_ITER);
        go_on    = not_conv && !cap_hit;
    end

    always_comb
    begin
        eval_req.start = (state_reg == T_LO_GO) || (state_reg == T_HI_GO)
                       || ((state_reg == T_CHECK) && go_on);
        case (state_reg)
            T_LO_GO: eval_req.x = lo_reg;
            T_HI_GO: eval_req.x = hi_reg;
            default: eval_req.x = mid_calc;
        endcase
    end

    assign in_ready = (state_reg == T_IDLE);
    assign out_load = (state_reg == T_OUT) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next   = state_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        mid_next     = mid_reg;
        iters_next   = iters_reg;
        status_next  = status_reg;
        sl_neg_next  = sl_neg_reg;
        sl_zero_next = sl_zero_reg;
        unique case (state_reg)
            T_IDLE:
            begin
                if (in_valid)
                begin
                    lo_next     = lower_bound;
                    hi_next     = upper_bound;
                    iters_next  = '0;
                    status_next = STATUS_CONVERGED;
                    mid_next    = '0;
                    state_next  = T_LO_GO;
                end
            end
            T_LO_GO:
            begin
                state_next = T_LO_WAIT;
            end
            T_LO_WAIT:
            begin
                if (eval_rsp.done)
                begin
                    sl_neg_next  = eval_rsp.neg;
                    sl_zero_next = eval_rsp.zero;
                    state_next   = T_HI_GO;
                end
            end
            T_HI_GO:
            begin
                state_next = T_HI_WAIT;
            end
            T_HI_WAIT:
            begin
                if (eval_rsp.done)
                begin
                    if (!sl_zero_reg && !eval_rsp.zero && (sl_neg_reg == eval_rsp.neg))
                    begin
                        mid_next    = '0;
                        status_next = STATUS_NO_CHANGE;
                        state_next  = T_OUT;
                    end
                    else
                    begin
                        mid_next   = mid_calc;
                        state_next = T_CHECK;
                    end
                end
            end
            T_CHECK:
            begin
                if (!not_conv)
                begin
                    status_next = STATUS_CONVERGED;
                    state_next  = T_OUT;
                end
                else if (cap_hit)
                begin
                    status_next = STATUS_CAP;
                    state_next  = T_OUT;
                end
                else
                begin
                    mid_next   = mid_calc;
                    state_next = T_MID_WAIT;
                end
            end
            T_MID_WAIT:
            begin
                if (eval_rsp.done)
                begin
                    if (!sl_zero_reg && !eval_rsp.zero && (sl_neg_reg != eval_rsp.neg))
                    begin
                        hi_next = mid_reg;
                    end
                    else
                    begin
                        lo_next      = mid_reg;
                        sl_neg_next  = eval_rsp.neg;
                        sl_zero_next = eval_rsp.zero;
                    end
                    iters_next = iters_reg + 1'b1;
                    state_next = T_CHECK;
                end
            end
            T_OUT:
            begin
                if (out_load)
                begin
                    state_next = T_IDLE;
                end
            end
            default:
            begin
                state_next = T_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= T_IDLE;
            iters_reg     <= '0;
            status_reg    <= STATUS_CONVERGED;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            iters_reg     <= iters_next;
            status_reg    <= status_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        mid_reg     <= mid_next;
        sl_neg_reg  <= sl_neg_next;
        sl_zero_reg <= sl_zero_next;
        if (out_load)
        begin
            root_reg       <= mid_reg;
            iter_out_reg   <= iters_reg;
            status_out_reg <= status_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign root       = root_reg;
    assign iterations = iter_out_reg;
    assign status     = status_out_reg;

    `BCRF_ASSERT_NEXT(a_accept_starts_eval, clk, rst_n, in_valid && in_ready, state_reg == T_LO_GO, "request not started")
    `BCRF_ASSERT(a_iter_within_cap, clk, rst_n, 1'b1, iters_reg <= ITER_W'(MAX_ITER), "step count above cap")
    `BCRF_ASSERT(a_no_change_result, clk, rst_n, state_reg == T_OUT && status_reg == STATUS_NO_CHANGE, iters_reg == '0 && mid_reg == '0, "bad no sign change result")

endmodule

>>> tb/bisection_cubic_root_finder_core_test.sv
// ----------------------------------------------------------------------------
// Bisection cubic root finder testbench
// Sends bracket requests to the core and checks every result against a table
// entry or a cycle-free predictor bisecting the cubic in exact wide arithmetic.
// A short table of hand-picked brackets runs first: range extremes, reversed
// and degenerate brackets, zero values of the cubic at an end and brackets
// that are already narrow enough. Random brackets follow under several
// coefficient and tolerance settings, written and read back over the
// register port while the core is idle. Both handshakes idle at random, with
// one calm stretch, and the receiver once holds off long enough to back up
// the request channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bisection_cubic_root_finder_core_test;

    import bcrf_pkg::*;

    localparam int MAX_STEPS = 40;
    localparam int N_SETS = 8;
    localparam int PER_SET = 204;
    localparam int HOLD_CYCLES = 4000;
    localparam int NUM_ROWS = 22;

    typedef struct packed {
        logic [Q_W-1:0]      root;
        logic [ITER_W-1:0]   iters;
        logic [STATUS_W-1:0] status;
    } outcome_t;

    typedef struct packed {
        logic [COEF_W-1:0] cube;
        logic [COEF_W-1:0] square;
        logic [COEF_W-1:0] linear;
        logic [COEF_W-1:0] bias;
        logic [TOL_W-1:0]  tol;
    } poly_t;

    typedef struct packed {
        logic [2:0]     set_id;
        logic [Q_W-1:0] lo;
        logic [Q_W-1:0] hi;
        logic           typed;
        outcome_t       want;
    } row_t;

    localparam outcome_t NO_OUTCOME = '{24'd0, 7'd0, STATUS_CONVERGED};
    localparam outcome_t NO_CHANGE  = '{24'd0, 7'd0, STATUS_NO_CHANGE};

    // Set 0 is the reset cubic 2x^3 + 3x - 1, set 1 is x^3 - x with exact
    // roots at -1, 0 and 1, sets 2 and 3 hold the register extremes.
    localparam row_t PLAN [NUM_ROWS] = '{
        '{3'd0, 24'h000000, 24'h010000, 1'b0, NO_OUTCOME},
        '{3'd0, 24'h010000, 24'h020000, 1'b1, NO_CHANGE},
        '{3'd0, 24'h800000, 24'h7FFFFF, 1'b0, NO_OUTCOME},
        '{3'd0, 24'h7FFFFF, 24'h800000, 1'b0, NO_OUTCOME},
        '{3'd0, 24'h800000, 24'hFFFFFF, 1'b1, NO_CHANGE},
        '{3'd0, 24'h7FFFFF, 24'h7FFFFF, 1'b1, NO_CHANGE},
        '{3'd0, 24'h800000, 24'h800000, 1'b1, NO_CHANGE},
        '{3'd0, 24'h010000, 24'h000000, 1'b0, NO_OUTCOME},
        '{3'd0, 24'd20496, 24'd20516, 1'b1, '{24'd20506, 7'd0, STATUS_CONVERGED}},
        '{3'd0, 24'd20506, 24'd20507, 1'b0, NO_OUTCOME},
        '{3'd0, 24'hFFFFFF, 24'h000001, 1'b1, NO_CHANGE},
        '{3'd1, 24'h000000, 24'h008000, 1'b0, NO_OUTCOME},
        '{3'd1, 24'hFF8000, 24'h000000, 1'b0, NO_OUTCOME},
        '{3'd1, 24'h010000, 24'h010000, 1'b1, '{24'h010000, 7'd0, STATUS_CONVERGED}},
        '{3'd1, 24'hFE0000, 24'h020000, 1'b0, NO_OUTCOME},
        '{3'd1, 24'h000000, 24'h000000, 1'b1, '{24'h000000, 7'd0, STATUS_CONVERGED}},
        '{3'd2, 24'h800000, 24'h7FFFFF, 1'b0, NO_OUTCOME},
        '{3'd2, 24'hFFFFFF, 24'h000000, 1'b0, NO_OUTCOME},
        '{3'd2, 24'h7FFFFF, 24'h7FFFFE, 1'b0, NO_OUTCOME},
        '{3'd2, 24'h000001, 24'h7FFFFF, 1'b0, NO_OUTCOME},
        '{3'd3, 24'h800000, 24'h7FFFFF, 1'b0, NO_OUTCOME},
        '{3'd3, 24'h7FFFFF, 24'h800000, 1'b0, NO_OUTCOME}
    };

    logic                clk = 1'b0;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;
    logic                in_valid;
    logic                in_ready;
    logic [Q_W-1:0]      lower_bound;
    logic [Q_W-1:0]      upper_bound;
    logic                out_valid;
    logic                out_ready;
    logic [Q_W-1:0]      root;
    logic [ITER_W-1:0]   iterations;
    logic [STATUS_W-1:0] status;

    poly_t    live;
    poly_t    coef_sets [N_SETS];
    outcome_t awaited_roots [$];
    int       error_count = 0;
    int       requests_sent = 0;
    int       roots_checked = 0;
    int       converged_seen = 0;
    int       no_change_seen = 0;
    int       cap_seen = 0;
    bit       calm = 1'b0;
    bit       hold_go = 1'b0;
    bit       hold_done = 1'b0;

    bisection_cubic_root_finder_core #(
        .MAX_ITER(MAX_STEPS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .lower_bound(lower_bound),
        .upper_bound(upper_bound),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .root(root),
        .iterations(iterations),
        .status(status)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic int cubic_sign(input logic signed [Q_W-1:0] x);
        logic signed [127:0] xw;
        logic signed [127:0] acc;
        logic signed [127:0] sq;
        logic signed [127:0] ln;
        logic signed [127:0] bs;
        xw = x;
        acc = $signed(live.cube);
        sq = $signed(live.square);
        ln = $signed(live.linear);
        bs = $signed(live.bias);
        acc = acc * xw + (sq <<< 16);
        acc = acc * xw + (ln <<< 32);
        acc = acc * xw + (bs <<< 48);
        if (acc < 0)
            return -1;
        return (acc == 0) ? 0 : 1;
    endfunction

    function automatic logic [Q_W-1:0] halfway(input logic signed [Q_W-1:0] a,
                                               input logic signed [Q_W-1:0] b);
        logic signed [Q_W:0] s;
        s = a + b;
        return s[Q_W:1];
    endfunction

    function automatic bit still_wide(input logic signed [Q_W-1:0] lo,
                                      input logic signed [Q_W-1:0] hi);
        longint a;
        longint b;
        longint d;
        a = lo;
        b = hi;
        d = b - a;
        if (d < 0)
            d = -d;
        if (b < 0)
            b = -b;
        return (d * 65536) > (longint'(live.tol) * b);
    endfunction

    function automatic outcome_t solve_bracket(input logic signed [Q_W-1:0] lo_in,
                                               input logic signed [Q_W-1:0] hi_in);
        logic signed [Q_W-1:0] lo;
        logic signed [Q_W-1:0] hi;
        logic signed [Q_W-1:0] mid;
        int                    steps;
        int                    s_lo;
        outcome_t              r;
        lo = lo_in;
        hi = hi_in;
        if (cubic_sign(lo) * cubic_sign(hi) > 0)
            return NO_CHANGE;
        r.status = STATUS_CONVERGED;
        steps = 0;
        mid = halfway(lo, hi);
        while (still_wide(lo, hi))
        begin
            if (steps >= MAX_STEPS)
            begin
                r.status = STATUS_CAP;
                break;
            end
            s_lo = cubic_sign(lo);
            mid = halfway(lo, hi);
            if (s_lo * cubic_sign(mid) < 0)
                hi = mid;
            else
                lo = mid;
            steps++;
        end
        r.root = mid;
        r.iters = ITER_W'(steps);
        return r;
    endfunction

    function automatic logic [Q_W-1:0] rand_mag(input int bits);
        return Q_W'($urandom_range(0, (1 << bits) - 1));
    endfunction

    function automatic logic [Q_W-1:0] rand_q(input int bits);
        logic [Q_W-1:0] m;
        m = rand_mag(bits);
        return $urandom_range(1) ? -m : m;
    endfunction

    function automatic logic [COEF_W-1:0] rand_coef(input int bits);
        logic [COEF_W-1:0] m;
        m = COEF_W'($urandom_range(0, (1 << bits) - 1));
        return $urandom_range(1) ? -m : m;
    endfunction

    task automatic note_error(input string what, input logic [DATA_W-1:0] want_v,
                              input logic [DATA_W-1:0] got_v);
        error_count++;
        if (error_count <= 10)
            $display("%t: %s mismatch: expected %0h, got %0h", $time, what, want_v, got_v);
    endtask

    always @(posedge clk)
    begin : check_result
        outcome_t want;
        if (rst_n && out_valid && out_ready)
        begin
            roots_checked++;
            if (awaited_roots.size() == 0)
            begin
                error_count++;
                if (error_count <= 10)
                    $display("%t: result with no request pending: root %0h status %0d",
                             $time, root, status);
            end
            else
            begin
                want = awaited_roots.pop_front();
                if (root !== want.root)
                    note_error("root", DATA_W'(want.root), DATA_W'(root));
                if (iterations !== want.iters)
                    note_error("iterations", DATA_W'(want.iters), DATA_W'(iterations));
                if (status !== want.status)
                    note_error("status", DATA_W'(want.status), DATA_W'(status));
                case (want.status)
                    STATUS_NO_CHANGE: no_change_seen++;
                    STATUS_CAP: cap_seen++;
                    default: converged_seen++;
                endcase
            end
        end
    end

    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_go && !hold_done)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done = 1'b1;
            end
            else
                out_ready <= calm || ($urandom_range(99) >= 13);
        end
    end

    initial
    begin
        #50_000_000;
        $display("Test completed with failures");
        $finish;
    end

    task automatic apb_write(input logic [REG_IDX_W-1:0] idx,
                             input logic [DATA_W-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
    endtask

    task automatic check_reg(input logic [REG_IDX_W-1:0] idx,
                             input logic [DATA_W-1:0] want_v,
                             input logic [DATA_W-1:0] mask);
        logic [DATA_W-1:0] got_v;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= {idx, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        got_v = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        if ((got_v & mask) !== (want_v & mask))
            note_error($sformatf("register %0d readback", idx), want_v & mask, got_v & mask);
    endtask

    task automatic program_set(input poly_t p);
        apb_write(REG_COEF_CUBE, p.cube);
        apb_write(REG_COEF_SQUARE, p.square);
        apb_write(REG_COEF_LINEAR, p.linear);
        apb_write(REG_COEF_CONST, p.bias);
        apb_write(REG_REL_TOL, DATA_W'(p.tol));
        live = p;
        check_reg(REG_COEF_CUBE, p.cube, '1);
        check_reg(REG_COEF_SQUARE, p.square, '1);
        check_reg(REG_COEF_LINEAR, p.linear, '1);
        check_reg(REG_COEF_CONST, p.bias, '1);
        check_reg(REG_REL_TOL, DATA_W'(p.tol), DATA_W'({TOL_W{1'b1}}));
    endtask

    task automatic send_request(input logic [Q_W-1:0] lo, input logic [Q_W-1:0] hi,
                                input outcome_t want);
        while (!calm && $urandom_range(99) < 13)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        lower_bound <= lo;
        upper_bound <= hi;
        do
            @(posedge clk);
        while (!in_ready);
        awaited_roots.push_back(want);
        requests_sent++;
    endtask

    task automatic settle_idle();
        in_valid <= 1'b0;
        while (awaited_roots.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic pick_bracket(output logic [Q_W-1:0] lo, output logic [Q_W-1:0] hi);
        int             kind;
        logic [Q_W-1:0] t;
        kind = $urandom_range(99);
        if (kind < 35)
        begin
            lo = Q_W'($urandom);
            hi = Q_W'($urandom);
        end
        else if (kind < 65)
        begin
            lo = -rand_mag($urandom_range(1, 23));
            hi = rand_mag($urandom_range(1, 23));
            if ($urandom_range(1))
            begin
                t = lo;
                lo = hi;
                hi = t;
            end
        end
        else if (kind < 85)
        begin
            lo = rand_q($urandom_range(1, 23));
            hi = lo + Q_W'($urandom_range(0, 8));
        end
        else
        begin
            lo = rand_q($urandom_range(1, 23));
            hi = rand_q($urandom_range(1, 23));
        end
    endtask

    initial
    begin : stimulus
        int             active_set;
        logic [Q_W-1:0] lo;
        logic [Q_W-1:0] hi;
        outcome_t       want;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_valid = 1'b0;
        lower_bound = '0;
        upper_bound = '0;
        coef_sets[0] = '{COEF_CUBE_RST, COEF_SQUARE_RST, COEF_LINEAR_RST, COEF_CONST_RST,
                         REL_TOL_RST};
        coef_sets[1] = '{32'h0001_0000, 32'h0000_0000, 32'hFFFF_0000, 32'h0000_0000,
                         16'd66};
        coef_sets[2] = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                         16'd1};
        coef_sets[3] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                         16'hFFFF};
        coef_sets[4] = '{rand_coef(19), rand_coef(19), rand_coef(19), rand_coef(19),
                         TOL_W'($urandom_range(1, 65535))};
        coef_sets[5] = '{$urandom, $urandom, $urandom, $urandom,
                         TOL_W'($urandom_range(1, 65535))};
        coef_sets[6] = '{32'h0000_0000, rand_coef(20), rand_coef(20), rand_coef(20),
                         TOL_W'($urandom_range(1, 8))};
        coef_sets[7] = '{rand_coef(17), rand_coef(17), rand_coef(20), rand_coef(20),
                         TOL_W'($urandom_range(1, 300))};
        live = coef_sets[0];
        active_set = 0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        check_reg(REG_COEF_CUBE, COEF_CUBE_RST, '1);
        check_reg(REG_COEF_SQUARE, COEF_SQUARE_RST, '1);
        check_reg(REG_COEF_LINEAR, COEF_LINEAR_RST, '1);
        check_reg(REG_COEF_CONST, COEF_CONST_RST, '1);
        check_reg(REG_REL_TOL, DATA_W'(REL_TOL_RST), DATA_W'({TOL_W{1'b1}}));

        for (int i = 0; i < NUM_ROWS; i++)
        begin
            if (PLAN[i].set_id != active_set)
            begin
                settle_idle();
                active_set = PLAN[i].set_id;
                program_set(coef_sets[active_set]);
            end
            want = PLAN[i].typed ? PLAN[i].want : solve_bracket(PLAN[i].lo, PLAN[i].hi);
            send_request(PLAN[i].lo, PLAN[i].hi, want);
        end

        for (int s = 0; s < N_SETS; s++)
        begin
            settle_idle();
            calm = (s == 3);
            program_set(coef_sets[s]);
            hold_go = (s == 4);
            for (int n = 0; n < PER_SET; n++)
            begin
                pick_bracket(lo, hi);
                send_request(lo, hi, solve_bracket(lo, hi));
            end
        end

        settle_idle();
        repeat (800) @(posedge clk);
        $display("Checked %0d results for %0d bracket requests over %0d coefficient sets.",
                 roots_checked, requests_sent, N_SETS);
        $display("Outcomes: %0d converged, %0d without a sign change, %0d at the step cap.",
                 converged_seen, no_change_seen, cap_seen);
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
